FILE: design/bloom_filter_insert_query_macros.svh
// Assertion macros of the bloom filter design, included by bfiq_back.
`ifndef BLOOM_FILTER_INSERT_QUERY_MACROS_SVH
`define BLOOM_FILTER_INSERT_QUERY_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define BFIQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define BFIQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/bfiq_pkg.sv
// Shared types and constants of the bloom filter insert/query block.
package bfiq_pkg;

  localparam int HASH_W     = 64;
  localparam int ROT_AMT    = 32;
  localparam int BIT_SEL_W  = 6;
  localparam int WCOUNT_W   = 13;
  localparam int NHASH_W    = 5;
  localparam int TDATA_OUT_W = 8;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // Status codes
  localparam logic ST_OK   = 1'b0;
  localparam logic ST_MISS = 1'b1;

  // Register word index (paddr[2])
  localparam logic REG_NUM_HASHES = 1'b0;
  localparam logic REG_WORD_COUNT = 1'b1;

  localparam logic [NHASH_W-1:0]  NUM_HASHES_RST = 5'd3;
  localparam logic [WCOUNT_W-1:0] WORD_COUNT_RST = 13'd4096;

  // Request queue: two entries
  localparam int QUEUE_DEPTH = 2;

  // Classified request: operation and double-hash seeds
  typedef struct packed {
    logic              op;
    logic [HASH_W-1:0] a;
    logic [HASH_W-1:0] b;
  } item_t;

  // Finished request result handed to the output queue
  typedef struct packed {
    logic valid;
    logic status;
  } res_t;

endpackage

FILE: design/bloom_filter_insert_query.sv
// Flow: a request with P probes (P = num_hashes, saturated; at least one slot) passes
// the issue stage, probe stages s1, s2 and s3, then the output queue. It is popped only
// once the previous one's probes are issued; one bit-array probe per cycle while busy,
// and at most two requests in flight between pop and the output handshake.
// Reset (rst, synchronous): registers return to defaults, then a clearing pass zeroes
// all MAX_WORDS words of the bit array while no request is accepted.
module bloom_filter_insert_query #(
  parameter int MAX_WORDS  = 4096,
  parameter int MAX_PROBES = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [bfiq_pkg::HASH_W-1:0]      s_tdata,   // [63:0] key_hash
  input  logic                             s_tuser,   // [0] operation
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [bfiq_pkg::TDATA_OUT_W-1:0] m_tdata,   // [0] status, [7:1] zero
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int PCW = $clog2(MAX_PROBES + 1);

  logic [bfiq_pkg::NHASH_W-1:0]  num_hashes;
  logic [bfiq_pkg::WCOUNT_W-1:0] word_count;

  logic                 clearing;
  logic                 pop;
  logic                 q_valid;
  bfiq_pkg::item_t      q_item;
  logic [PCW-1:0]       q_probes;
  bfiq_pkg::res_t       res;
  logic                 res_full;
  logic                 res_taken;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_hashes <= bfiq_pkg::NUM_HASHES_RST;
      word_count <= bfiq_pkg::WORD_COUNT_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        bfiq_pkg::REG_NUM_HASHES: num_hashes <= pwdata[bfiq_pkg::NHASH_W-1:0];
        bfiq_pkg::REG_WORD_COUNT: word_count <= pwdata[bfiq_pkg::WCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (paddr[2])
      bfiq_pkg::REG_NUM_HASHES: prdata = 32'(num_hashes);
      bfiq_pkg::REG_WORD_COUNT: prdata = 32'(word_count);
      default:                  prdata = '0;
    endcase
  end

  bfiq_front #(
    .MAX_PROBES (MAX_PROBES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .num_hashes (num_hashes),
    .clearing   (clearing),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_probes   (q_probes)
  );

  bfiq_back #(
    .MAX_WORDS  (MAX_WORDS),
    .MAX_PROBES (MAX_PROBES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_probes   (q_probes),
    .pop        (pop),
    .word_count (word_count),
    .res_taken  (res_taken),
    .res_full   (res_full),
    .res        (res),
    .clearing   (clearing)
  );

  bfiq_result u_result (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .res_full  (res_full),
    .res_taken (res_taken),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

FILE: design/bfiq_front.sv
// Front end: accepts requests, derives probe seeds and count, queues them.
module bfiq_front #(
  parameter int MAX_PROBES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [bfiq_pkg::HASH_W-1:0]   s_tdata,   // [63:0] key_hash
  input  logic                          s_tuser,   // [0] operation
  input  logic [bfiq_pkg::NHASH_W-1:0]  num_hashes,
  input  logic                          clearing,
  input  logic                          pop,
  output logic                          q_valid,
  output bfiq_pkg::item_t               q_item,
  output logic [$clog2(MAX_PROBES+1)-1:0] q_probes
);

  localparam int PCW = $clog2(MAX_PROBES + 1);

  bfiq_pkg::item_t   ent_item   [bfiq_pkg::QUEUE_DEPTH];
  logic [PCW-1:0]    ent_probes [bfiq_pkg::QUEUE_DEPTH];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;

  bfiq_pkg::item_t   new_item;
  logic [PCW-1:0]    new_probes;
  logic              push;

  // Classify: rotate hash for the first seed, saturate the probe count
  always_comb begin
    new_item.op = s_tuser;
    new_item.a  = {s_tdata[bfiq_pkg::ROT_AMT-1:0],
                   s_tdata[bfiq_pkg::HASH_W-1:bfiq_pkg::ROT_AMT]};
    new_item.b  = s_tdata;
    if (32'(num_hashes) > 32'(MAX_PROBES)) begin
      new_probes = PCW'(MAX_PROBES);
    end else begin
      new_probes = PCW'(num_hashes);
    end
  end

  assign s_tready = (count != 2'(bfiq_pkg::QUEUE_DEPTH)) && !clearing;
  assign push     = s_tvalid && s_tready;

  assign q_valid  = (count != 2'd0);
  assign q_item   = ent_item[rd_ptr];
  assign q_probes = ent_probes[rd_ptr];

  // Store entry payload
  always_ff @(posedge clk) begin
    if (push) begin
      ent_item[wr_ptr]   <= new_item;
      ent_probes[wr_ptr] <= new_probes;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: design/bfiq_back.sv
// Back end: probe sequencer, range reduction, bit array with read-modify-write.
module bfiq_back #(
  parameter int MAX_WORDS  = 4096,
  parameter int MAX_PROBES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  bfiq_pkg::item_t                 q_item,
  input  logic [$clog2(MAX_PROBES+1)-1:0] q_probes,
  output logic                            pop,
  input  logic [bfiq_pkg::WCOUNT_W-1:0]   word_count,
  input  logic                            res_taken,
  input  logic                            res_full,
  output bfiq_pkg::res_t                  res,
  output logic                            clearing
);

  localparam int PCW  = $clog2(MAX_PROBES + 1);
  localparam int IDXW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int PRODW = bfiq_pkg::HASH_W + bfiq_pkg::WCOUNT_W;

  // Issue stage
  logic                        busy;
  logic [bfiq_pkg::HASH_W-1:0] a;
  logic [bfiq_pkg::HASH_W-1:0] b;
  logic                        op;
  logic [PCW-1:0]              remain;
  logic [1:0]                  outstanding;

  // Probe stage 1: seed value
  logic                        s1_valid;
  logic [bfiq_pkg::HASH_W-1:0] s1_a;
  logic                        s1_op;
  logic                        s1_last;
  logic                        s1_nop;

  // Probe stage 2: word index, memory read issued
  logic                          s2_valid;
  logic [IDXW-1:0]               s2_word;
  logic [bfiq_pkg::BIT_SEL_W-1:0] s2_bit;
  logic                          s2_op;
  logic                          s2_last;
  logic                          s2_nop;

  // Probe stage 3: word data back, check or set
  logic                          s3_valid;
  logic [IDXW-1:0]               s3_word;
  logic [bfiq_pkg::BIT_SEL_W-1:0] s3_bit;
  logic                          s3_op;
  logic                          s3_last;
  logic                          s3_nop;
  logic                          miss_acc;

  // Last write, for read-after-write forwarding
  logic                        wr_valid;
  logic [IDXW-1:0]             wr_addr;
  logic [bfiq_pkg::HASH_W-1:0] wr_data;

  // Clearing pass
  logic            clr_active;
  logic [IDXW-1:0] clr_addr;

  logic [bfiq_pkg::HASH_W-1:0] mem [MAX_WORDS];
  logic [bfiq_pkg::HASH_W-1:0] rd_data;

  logic [bfiq_pkg::WCOUNT_W-1:0] words;
  logic [PRODW-1:0]              prod;
  logic [bfiq_pkg::HASH_W-1:0]   cur_word;
  logic [bfiq_pkg::HASH_W-1:0]   set_word;
  logic                          hit;
  logic                          ins_now;
  logic                          miss_now;
  logic                          mem_we;
  logic [IDXW-1:0]               mem_waddr;
  logic [bfiq_pkg::HASH_W-1:0]   mem_wdata;

  assign clearing = clr_active;
  assign pop      = q_valid && !busy && !clr_active && (outstanding < 2'd2);

  // Saturate the array size and reduce the seed into it
  always_comb begin
    if (32'(word_count) > 32'(MAX_WORDS)) begin
      words = bfiq_pkg::WCOUNT_W'(MAX_WORDS);
    end else begin
      words = word_count;
    end
  end
  assign prod = PRODW'(s1_a) * PRODW'(words);

  // Check or set the probed bit, forwarding the previous cycle's write
  always_comb begin
    if (wr_valid && (wr_addr == s3_word)) begin
      cur_word = wr_data;
    end else begin
      cur_word = rd_data;
    end
    hit      = cur_word[s3_bit];
    set_word = cur_word | (bfiq_pkg::HASH_W'(1) << s3_bit);
    ins_now  = s3_valid && !s3_nop && (s3_op == bfiq_pkg::OP_INSERT);
    miss_now = s3_valid && !s3_nop && (s3_op == bfiq_pkg::OP_QUERY) && !hit;
  end

  // Memory write port: clearing pass, else insert write-back
  always_comb begin
    if (clr_active) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = ins_now;
      mem_waddr = s3_word;
      mem_wdata = set_word;
    end
  end

  // Bit array: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[s2_word];
  end

  // Result of the last probe of a request
  always_comb begin
    res.valid  = s3_valid && s3_last;
    res.status = (miss_acc || miss_now) ? bfiq_pkg::ST_MISS : bfiq_pkg::ST_OK;
  end

  // Probe datapath payload
  always_ff @(posedge clk) begin
    if (pop) begin
      a      <= q_item.a;
      b      <= q_item.b;
      op     <= q_item.op;
      remain <= q_probes;
    end else if (busy) begin
      a      <= a + b;
      remain <= remain - PCW'(1);
    end
    s1_a    <= a;
    s1_op   <= op;
    s1_last <= (remain <= PCW'(1));
    s1_nop  <= (remain == '0);
    s2_word <= IDXW'(prod[PRODW-1:bfiq_pkg::HASH_W]);
    s2_bit  <= s1_a[bfiq_pkg::BIT_SEL_W-1:0];
    s2_op   <= s1_op;
    s2_last <= s1_last;
    s2_nop  <= s1_nop;
    s3_word <= s2_word;
    s3_bit  <= s2_bit;
    s3_op   <= s2_op;
    s3_last <= s2_last;
    s3_nop  <= s2_nop;
    wr_addr <= s3_word;
    wr_data <= set_word;
  end

  // Control: sequencer, pipeline valids, clearing pass, request count
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      s3_valid    <= 1'b0;
      wr_valid    <= 1'b0;
      miss_acc    <= 1'b0;
      outstanding <= 2'd0;
      clr_active  <= 1'b1;
      clr_addr    <= '0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (busy && (remain <= PCW'(1))) begin
        busy <= 1'b0;
      end
      s1_valid <= busy;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      wr_valid <= ins_now && !clr_active;
      if (s3_valid) begin
        if (s3_last) begin
          miss_acc <= 1'b0;
        end else begin
          miss_acc <= miss_acc || miss_now;
        end
      end
      case ({pop, res_taken})
        2'b10:   outstanding <= outstanding + 2'd1;
        2'b01:   outstanding <= outstanding - 2'd1;
        default: outstanding <= outstanding;
      endcase
      if (clr_active) begin
        if (clr_addr == IDXW'(MAX_WORDS - 1)) begin
          clr_active <= 1'b0;
        end else begin
          clr_addr <= clr_addr + IDXW'(1);
        end
      end
    end
  end

`include "bloom_filter_insert_query_macros.svh"

  `BFIQ_ASSERT_NOW(a_no_pop_clearing, clr_active, !pop, "request started during clearing pass")
  `BFIQ_ASSERT_NOW(a_outstanding_max, 1'b1, outstanding <= 2'd2, "too many requests in flight")
  `BFIQ_ASSERT_NOW(a_result_room, res.valid, !res_full, "result produced with output queue full")
  `BFIQ_ASSERT_NEXT(a_pop_starts, pop, busy, "sequencer did not start after pop")

endmodule

FILE: design/bfiq_result.sv
// Output queue: holds finished request results until the sink takes them.
module bfiq_result (
  input  logic                               clk,
  input  logic                               rst,
  input  bfiq_pkg::res_t                     res,
  output logic                               res_full,
  output logic                               res_taken,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [bfiq_pkg::TDATA_OUT_W-1:0]   m_tdata    // [0] status, [7:1] zero
);

  logic       ent_status [bfiq_pkg::QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign m_tvalid  = (count != 2'd0);
  assign res_full  = (count == 2'(bfiq_pkg::QUEUE_DEPTH));
  assign res_taken = m_tvalid && m_tready;
  assign m_tdata   = {(bfiq_pkg::TDATA_OUT_W-1)'(0), ent_status[rd_ptr]};

  // Store result payload
  always_ff @(posedge clk) begin
    if (res.valid) begin
      ent_status[wr_ptr] <= res.status;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (res.valid) begin
        wr_ptr <= ~wr_ptr;
      end
      if (res_taken) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({res.valid, res_taken})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: test/bloom_filter_insert_query_test.sv
// Self-checking testbench for the bloom filter insert/query block.

// Tracks the filter contents and the status each request must return.
class membership_model;
  localparam int MAX_WORDS  = 4096;
  localparam int MAX_PROBES = 16;

  logic [63:0] filter_words[MAX_WORDS];
  logic [bfiq_pkg::NHASH_W-1:0] probe_count;
  logic [bfiq_pkg::WCOUNT_W-1:0] word_limit;
  logic pending_status[$];
  int errors;

  function new();
    foreach (filter_words[i]) filter_words[i] = 64'd0;
    probe_count = bfiq_pkg::NUM_HASHES_RST;
    word_limit  = bfiq_pkg::WORD_COUNT_RST;
    errors = 0;
  endfunction

  function void configure(logic idx, logic [31:0] value);
    if (idx == bfiq_pkg::REG_NUM_HASHES) begin
      probe_count = value[bfiq_pkg::NHASH_W-1:0];
    end else begin
      word_limit = value[bfiq_pkg::WCOUNT_W-1:0];
    end
  endfunction

  // Walk the double-hash probe sequence, updating or testing the bits.
  function void note_request(logic op, logic [63:0] key);
    logic [63:0] a;
    logic [63:0] b;
    logic [127:0] product;
    logic [127:0] span;
    int unsigned probes;
    int unsigned w;
    int unsigned i;
    logic status;
    a = {key[31:0], key[63:32]};
    b = key;
    probes = (probe_count > MAX_PROBES) ? MAX_PROBES : probe_count;
    span = 128'((word_limit > MAX_WORDS) ? MAX_WORDS : word_limit);
    status = bfiq_pkg::ST_OK;
    for (i = 0; i < probes; i++) begin
      product = {64'd0, a} * span;
      w = product[95:64];
      if (w >= MAX_WORDS) w = 0;
      if (op == bfiq_pkg::OP_QUERY) begin
        if (filter_words[w][a[5:0]] == 1'b0) begin
          status = bfiq_pkg::ST_MISS;
          break;
        end
      end else begin
        filter_words[w][a[5:0]] = 1'b1;
      end
      a = a + b;
    end
    pending_status.push_back(status);
  endfunction

  function void check_status(logic [7:0] tdata);
    logic want;
    if (pending_status.size() == 0) begin
      $error("unexpected result: status %0d with no request outstanding", tdata[0]);
      errors++;
    end else begin
      want = pending_status.pop_front();
      if (tdata[0] !== want) begin
        $error("status: expected %0d, actual %0d", want, tdata[0]);
        errors++;
      end
    end
  endfunction

  function int outstanding();
    return pending_status.size();
  endfunction
endclass

module bloom_filter_insert_query_test;
  localparam int MAX_WORDS     = 4096;
  localparam int MAX_PROBES    = 16;
  localparam int RX_HOLD       = 300;
  localparam int IDLE_LIMIT    = 20000;
  localparam int END_SETTLE    = 60;
  localparam int PHASE_ITEMS   = 110;
  localparam int BURST_ITEMS   = 40;
  localparam int NUM_PHASES    = 11;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;   // [63:0] key_hash
  logic        s_tuser;   // [0] operation
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // [0] status, [7:1] zero
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  membership_model model = new();

  logic [63:0] inserted_keys[$];
  bit          tx_steady;
  bit          rx_steady;
  bit          rx_hold_request;
  int          idle_cycles;

  // Phase settings: probes, words, no idling, long receiver hold
  int unsigned phase_probes[NUM_PHASES] = '{4, 16, 0, 1, 31, 17, 7, 2, 10, 16, 5};
  int unsigned phase_words[NUM_PHASES]  =
    '{4096, 4096, 4096, 1, 8191, 0, 4097, 100, 33, 2, 4096};
  bit phase_steady[NUM_PHASES] = '{0, 1, 0, 0, 0, 0, 1, 0, 0, 0, 0};
  bit phase_hold[NUM_PHASES]   = '{0, 1, 0, 0, 0, 1, 0, 0, 0, 0, 1};

  bloom_filter_insert_query #(
    .MAX_WORDS (MAX_WORDS),
    .MAX_PROBES(MAX_PROBES)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Check every accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) model.check_status(m_tdata);
  end

  // End the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((s_tvalid === 1'b1 && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready === 1'b1))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("bloom_filter_insert_query_test: FAIL");
      $finish;
    end
  end

  // Receiver: runs of ready and stall, or one long hold when asked.
  initial begin
    int run;
    bit level;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_request) begin
        level = 1'b0;
        run = RX_HOLD;
      end else if (rx_steady || $urandom_range(0, 3) != 0) begin
        level = 1'b1;
        run = rx_steady ? 1 : $urandom_range(1, 16);
      end else begin
        level = 1'b0;
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
      end
      m_tready <= level;
      repeat (run - 1) @(negedge clk);
      if (!level && run == RX_HOLD) rx_hold_request = 0;
    end
  end

  // Offer one request and hold it until accepted.
  task automatic send_request(logic op, logic [63:0] key);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= key;
    do @(posedge clk); while (s_tready !== 1'b1);
    model.note_request(op, key);
  endtask

  // Drop valid for a random gap, mostly short.
  task automatic sender_gap();
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    if (tx_steady || pick < 60) gap = 0;
    else if (pick < 90) gap = $urandom_range(1, 3);
    else if (pick < 98) gap = $urandom_range(4, 12);
    else gap = $urandom_range(30, 80);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Stop offering and wait for every outstanding result.
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (model.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    model.configure(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [63:0] random_key();
    logic [63:0] one_hot;
    one_hot = 64'd1 << $urandom_range(0, 63);
    case ($urandom_range(0, 19))
      0: return 64'd0;
      1: return '1;
      2: return one_hot;
      3: return ~one_hot;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly inserts and queries of known keys, plus misses and near misses.
  task automatic random_request();
    int pick;
    logic [63:0] key;
    pick = $urandom_range(0, 99);
    if (pick < 40 || inserted_keys.size() == 0) begin
      key = random_key();
      inserted_keys.push_back(key);
      if (inserted_keys.size() > 256) void'(inserted_keys.pop_front());
      send_request(bfiq_pkg::OP_INSERT, key);
    end else if (pick < 75) begin
      key = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
      send_request(bfiq_pkg::OP_QUERY, key);
    end else if (pick < 88) begin
      send_request(bfiq_pkg::OP_QUERY, random_key());
    end else begin
      key = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
      send_request(bfiq_pkg::OP_QUERY, key ^ (64'd1 << $urandom_range(0, 63)));
    end
    sender_gap();
  endtask

  // Program both registers, sometimes with junk above the field.
  task automatic program_filter(int unsigned probes, int unsigned words);
    logic [31:0] junk;
    junk = $urandom_range(0, 1) ? $urandom : 32'd0;
    write_reg(bfiq_pkg::REG_NUM_HASHES, {junk[31:bfiq_pkg::NHASH_W], probes[4:0]});
    junk = $urandom_range(0, 1) ? $urandom : 32'd0;
    write_reg(bfiq_pkg::REG_WORD_COUNT, {junk[31:bfiq_pkg::WCOUNT_W], words[12:0]});
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = bfiq_pkg::OP_INSERT;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tx_steady = 0;
    rx_steady = 0;
    rx_hold_request = 0;
    idle_cycles = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed: extreme keys at reset settings, queried before and after insertion, some never inserted
    send_request(bfiq_pkg::OP_QUERY, 64'd0);
    send_request(bfiq_pkg::OP_INSERT, 64'd0);
    send_request(bfiq_pkg::OP_QUERY, 64'd0);
    send_request(bfiq_pkg::OP_INSERT, '1);
    send_request(bfiq_pkg::OP_QUERY, '1);
    send_request(bfiq_pkg::OP_QUERY, 64'd1);
    send_request(bfiq_pkg::OP_INSERT, 64'd1);
    send_request(bfiq_pkg::OP_QUERY, 64'd1);
    send_request(bfiq_pkg::OP_INSERT, 64'h8000_0000_0000_0000);
    send_request(bfiq_pkg::OP_QUERY, 64'h8000_0000_0000_0000);
    send_request(bfiq_pkg::OP_INSERT, 64'h0000_0001_0000_0000);
    send_request(bfiq_pkg::OP_QUERY, 64'h0000_0001_0000_0000);
    send_request(bfiq_pkg::OP_QUERY, 64'hFFFF_FFFF_0000_0000);
    send_request(bfiq_pkg::OP_QUERY, 64'h0000_0000_FFFF_FFFF);
    send_request(bfiq_pkg::OP_INSERT, 64'h5555_5555_5555_5555);
    send_request(bfiq_pkg::OP_QUERY, 64'h5555_5555_5555_5555);
    send_request(bfiq_pkg::OP_QUERY, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(bfiq_pkg::OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(bfiq_pkg::OP_QUERY, 64'hAAAA_AAAA_AAAA_AAAA);
    drain();

    // Random phases across register settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      program_filter(phase_probes[p], phase_words[p]);
      inserted_keys.delete();
      tx_steady = phase_steady[p];
      rx_steady = phase_steady[p];
      repeat (PHASE_ITEMS) random_request();
      if (phase_hold[p]) begin
        // Back-pressure: receiver holds off while requests keep coming
        rx_steady = 0;
        tx_steady = 1;
        rx_hold_request = 1;
        repeat (BURST_ITEMS) random_request();
      end
      drain();
    end

    repeat (END_SETTLE) @(posedge clk);
    if (model.outstanding() != 0) begin
      $error("%0d results never arrived", model.outstanding());
      model.errors++;
    end
    if (model.errors == 0) begin
      $display("bloom_filter_insert_query_test: PASS");
    end else begin
      $display("bloom_filter_insert_query_test: FAIL");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+design
design/bfiq_pkg.sv
design/bfiq_front.sv
design/bfiq_back.sv
design/bfiq_result.sv
design/bloom_filter_insert_query.sv
test/bloom_filter_insert_query_test.sv
